/* src/tensor_partial_index_assert.svh */
// Assertion macros shared by the checker of the index block.
`ifndef TENSOR_PARTIAL_INDEX_ASSERT_SVH
`define TENSOR_PARTIAL_INDEX_ASSERT_SVH

// Checked only while out of reset.
`define TPI_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Checked at every edge, reset included.
`define TPI_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

/* src/tpi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tpi_pkg;

    localparam int MAX_DIMS   = 8;
    localparam int NODE_COUNT = 4;

    localparam int IDX_W    = 31;
    localparam int NODE_W   = 2;
    localparam int RADIX_W  = 8;
    localparam int DIM_W    = 3;
    localparam int CNT_W    = 4;
    localparam int ROW_W    = 28;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    localparam int STEP_MAX   = 8;
    localparam int DIV_SUBS   = (IDX_W + STEP_MAX - 1) / STEP_MAX;
    localparam int STEP_LAST  = IDX_W - (DIV_SUBS - 1) * STEP_MAX;
    localparam int DIV_STAGES = MAX_DIMS * DIV_SUBS;
    localparam int REC_STAGES = MAX_DIMS;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX_TABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_THREE   = 3'd5;

    typedef struct packed {
        logic [RADIX_W-1:0] rem;
        logic [IDX_W-1:0]   q;
    } div_t;

    function automatic logic [RADIX_W-1:0] radix_eff(logic [CFG_W-1:0] table_bits,
                                                      logic [DIM_W-1:0] dim);
        logic [RADIX_W-1:0] r;
        r = table_bits[dim*RADIX_W +: RADIX_W];
        return (r == '0) ? RADIX_W'(1) : r;
    endfunction

    function automatic logic [CNT_W-1:0] dims_of(logic [CNT_W-1:0] cnt);
        if (cnt == '0) begin
            return CNT_W'(1);
        end else if (32'(cnt) > MAX_DIMS) begin
            return CNT_W'(MAX_DIMS);
        end
        return cnt;
    endfunction

    function automatic div_t div_steps(div_t a, logic [RADIX_W-1:0] r, int steps);
        div_t v;
        logic [RADIX_W:0] t;
        v = a;
        for (int i = 0; i < STEP_MAX; i++) begin
            if (i < steps) begin
                t = {v.rem, v.q[IDX_W-1]};
                v.q = {v.q[IDX_W-2:0], 1'b0};
                if (t >= {1'b0, r}) begin
                    t = t - {1'b0, r};
                    v.q[0] = 1'b1;
                end
                v.rem = t[RADIX_W-1:0];
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/tensor_partial_index.sv */
// Mixed-radix partial index unit. A full linear index is split into per-dimension
// digits by a chain of restoring dividers, up to eight quotient bits per stage and
// four stages per dimension, and the digits of the selected node's row are then
// recombined in one multiply-add stage per row position. The block takes one beat
// per cycle; a stalled output holds the whole pipeline. Configuration is to be written
// by the user only while no beat is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module tensor_partial_index
    import tpi_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [IDX_W-1:0]     s_full_index,
    input  wire logic [NODE_W-1:0]    s_node_select,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [IDX_W-1:0]          m_partial_index
);

    logic [CNT_W-1:0] dim_count_reg;
    logic [CFG_W-1:0] radix_table_reg;
    logic [ROW_W-1:0] rows_reg [NODE_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_count_reg   <= CNT_W'(1);
            radix_table_reg <= {(CFG_W/RADIX_W){RADIX_W'(1)}};
            for (int i = 0; i < NODE_COUNT; i++) begin
                rows_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIM_COUNT:   dim_count_reg   <= cfg_data[CNT_W-1:0];
                REG_RADIX_TABLE: radix_table_reg <= cfg_data;
                REG_ROW_ZERO:    rows_reg[0]     <= cfg_data[ROW_W-1:0];
                REG_ROW_ONE:     rows_reg[1]     <= cfg_data[ROW_W-1:0];
                REG_ROW_TWO:     rows_reg[2]     <= cfg_data[ROW_W-1:0];
                REG_ROW_THREE:   rows_reg[3]     <= cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] dims;
    logic             en;

    assign dims    = dims_of(dim_count_reg);
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic                 div_valid_reg [DIV_STAGES];
    logic [ROW_W-1:0]     div_row_reg   [DIV_STAGES];
    div_t                 div_st_reg    [DIV_STAGES];
    logic [RADIX_W-1:0]   div_digit_reg [DIV_STAGES][MAX_DIMS];

    logic                 rec_valid_reg [REC_STAGES];
    logic [ROW_W-1:0]     rec_row_reg   [REC_STAGES];
    logic [RADIX_W-1:0]   rec_digit_reg [REC_STAGES][MAX_DIMS];
    logic [IDX_W-1:0]     rec_pos_reg   [REC_STAGES];
    logic [IDX_W-1:0]     rec_w_reg     [REC_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        localparam int K   = s / DIV_SUBS;
        localparam int SUB = s % DIV_SUBS;
        localparam int STEPS = (SUB == DIV_SUBS - 1) ? STEP_LAST : STEP_MAX;

        logic               in_valid;
        logic [ROW_W-1:0]   in_row;
        div_t               in_st;
        logic [RADIX_W-1:0] in_digit [MAX_DIMS];
        div_t               st_next;
        logic [RADIX_W-1:0] digit_next [MAX_DIMS];

        if (s == 0) begin : g_head
            always_comb begin
                in_valid = s_valid;
                in_row   = (32'(s_node_select) < NODE_COUNT) ? rows_reg[s_node_select] : '0;
                in_st.rem = '0;
                in_st.q   = s_full_index;
                for (int i = 0; i < MAX_DIMS; i++) begin
                    in_digit[i] = '0;
                end
            end
        end else begin : g_link
            always_comb begin
                in_valid = div_valid_reg[s-1];
                in_row   = div_row_reg[s-1];
                in_st    = div_st_reg[s-1];
                if (SUB == 0) begin
                    in_st.rem = '0;
                end
                for (int i = 0; i < MAX_DIMS; i++) begin
                    in_digit[i] = div_digit_reg[s-1][i];
                end
            end
        end

        always_comb begin
            st_next = div_steps(in_st, radix_eff(radix_table_reg, DIM_W'(K)), STEPS);
            for (int i = 0; i < MAX_DIMS; i++) begin
                digit_next[i] = in_digit[i];
            end
            if (SUB == DIV_SUBS - 1) begin
                digit_next[K] = (32'(dims) > K) ? st_next.rem : '0;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[s] <= 1'b0;
            end else if (en) begin
                div_valid_reg[s] <= in_valid;
            end
            if (en) begin
                div_row_reg[s] <= in_row;
                div_st_reg[s]  <= st_next;
                for (int i = 0; i < MAX_DIMS; i++) begin
                    div_digit_reg[s][i] <= digit_next[i];
                end
            end
        end
    end

    for (genvar p = 0; p < REC_STAGES; p++) begin : g_rec
        logic               in_valid;
        logic [ROW_W-1:0]   in_row;
        logic [RADIX_W-1:0] in_digit [MAX_DIMS];
        logic [IDX_W-1:0]   in_pos;
        logic [IDX_W-1:0]   in_w;
        logic [CNT_W-1:0]   len;
        logic [DIM_W-1:0]   dim;
        logic [RADIX_W-1:0] d;
        logic [IDX_W-1:0]   pos_next;
        logic [IDX_W-1:0]   w_next;

        if (p == 0) begin : g_head
            always_comb begin
                in_valid = div_valid_reg[DIV_STAGES-1];
                in_row   = div_row_reg[DIV_STAGES-1];
                in_pos   = '0;
                in_w     = IDX_W'(1);
                for (int i = 0; i < MAX_DIMS; i++) begin
                    in_digit[i] = div_digit_reg[DIV_STAGES-1][i];
                end
            end
        end else begin : g_link
            always_comb begin
                in_valid = rec_valid_reg[p-1];
                in_row   = rec_row_reg[p-1];
                in_pos   = rec_pos_reg[p-1];
                in_w     = rec_w_reg[p-1];
                for (int i = 0; i < MAX_DIMS; i++) begin
                    in_digit[i] = rec_digit_reg[p-1][i];
                end
            end
        end

        always_comb begin
            len = in_row[ROW_W-1 -: CNT_W];
            if (32'(len) > MAX_DIMS) begin
                len = CNT_W'(MAX_DIMS);
            end
            dim      = in_row[p*DIM_W +: DIM_W];
            d        = (len == dims) ? in_digit[p] : in_digit[dim];
            pos_next = in_pos;
            w_next   = in_w;
            if (32'(len) > p) begin
                pos_next = in_pos + IDX_W'(d * in_w);
                w_next   = IDX_W'(in_w * radix_eff(radix_table_reg, dim));
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rec_valid_reg[p] <= 1'b0;
            end else if (en) begin
                rec_valid_reg[p] <= in_valid;
            end
            if (en) begin
                rec_row_reg[p] <= in_row;
                rec_pos_reg[p] <= pos_next;
                rec_w_reg[p]   <= w_next;
                for (int i = 0; i < MAX_DIMS; i++) begin
                    rec_digit_reg[p][i] <= in_digit[i];
                end
            end
        end
    end

    assign m_valid         = rec_valid_reg[REC_STAGES-1];
    assign m_partial_index = rec_pos_reg[REC_STAGES-1];

endmodule

`default_nettype wire

/* src/tpi_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "tensor_partial_index_assert.svh"

module tpi_assert_checker
    import tpi_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [IDX_W-1:0] m_partial_index
);

    // A result that is not taken stays on the port unchanged.
    `TPI_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_partial_index))

    // Input is refused only while a result waits on a stalled output.
    `TPI_ASSERT(a_ready_rule, aclk, aresetn, s_ready == (!m_valid || m_ready))

    // Reset empties the pipeline.
    `TPI_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // A refused input beat can only coincide with a waiting result.
    `TPI_ASSERT(a_stall_cause, aclk, aresetn, s_valid && !s_ready |-> m_valid)

endmodule

bind tensor_partial_index tpi_assert_checker u_tpi_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_partial_index (m_partial_index)
);

`default_nettype wire

/* sim/tpi_checker.sv */
`timescale 1ns / 1ps

module tpi_checker
    import tpi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [IDX_W-1:0]     s_full_index,
    input  logic [NODE_W-1:0]    s_node_select,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [IDX_W-1:0]     m_partial_index,
    output int                   fail_count,
    output int                   pending_count
);

    logic [CNT_W-1:0]   dims_reg;
    logic [CFG_W-1:0]   radices;
    logic [ROW_W-1:0]   rows [NODE_COUNT];
    logic [IDX_W-1:0]   partial_queue [$];

    function automatic logic [63:0] radix_at(logic [CFG_W-1:0] tbl, int d);
        logic [7:0] r;
        r = tbl[d*8 +: 8];
        return (r == 8'd0) ? 64'd1 : 64'(r);
    endfunction

    function automatic logic [IDX_W-1:0] partial_of(logic [IDX_W-1:0] full,
                                                    logic [NODE_W-1:0] node);
        logic [63:0] digits [8];
        logic [63:0] rest, acc, w, dg;
        logic [ROW_W-1:0] row;
        int nd, len, dim;
        rest = 64'(full);
        acc = 0;
        w = 1;
        nd = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS ? MAX_DIMS : int'(dims_reg));
        for (int n = 0; n < 8; n++) begin
            digits[n] = 0;
        end
        for (int n = 0; n < nd; n++) begin
            digits[n] = rest % radix_at(radices, n);
            rest = rest / radix_at(radices, n);
        end
        row = rows[node];
        len = int'(row[27:24]);
        if (len > MAX_DIMS) begin
            len = MAX_DIMS;
        end
        for (int n = 0; n < len; n++) begin
            dim = int'(row[3*n +: 3]);
            if (len == nd) begin
                dg = digits[n];
            end else begin
                dg = (dim < nd) ? digits[dim] : 64'd0;
            end
            acc = acc + dg * w;
            w = w * radix_at(radices, dim);
        end
        return acc[IDX_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= 4'd1;
            radices <= 64'h0101010101010101;
            for (int i = 0; i < NODE_COUNT; i++) begin
                rows[i] <= '0;
            end
            partial_queue.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DIM_COUNT: dims_reg <= cfg_data[CNT_W-1:0];
                    REG_RADIX_TABLE: radices <= cfg_data;
                    REG_ROW_ZERO: rows[0] <= cfg_data[ROW_W-1:0];
                    REG_ROW_ONE: rows[1] <= cfg_data[ROW_W-1:0];
                    REG_ROW_TWO: rows[2] <= cfg_data[ROW_W-1:0];
                    REG_ROW_THREE: rows[3] <= cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                partial_queue.push_back(partial_of(s_full_index, s_node_select));
            end
            if (m_valid && m_ready) begin
                if (partial_queue.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %0d",
                             $time, m_partial_index);
                    fail_count <= fail_count + 1;
                end else if (partial_queue[0] !== m_partial_index) begin
                    $display("%0t: partial_index expected %0d, actual %0d",
                             $time, partial_queue[0], m_partial_index);
                    fail_count <= fail_count + 1;
                    void'(partial_queue.pop_front());
                end else begin
                    void'(partial_queue.pop_front());
                end
            end
        end
    end

    assign pending_count = partial_queue.size();

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import tpi_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [IDX_W-1:0]     s_full_index;
    logic [NODE_W-1:0]    s_node_select;
    logic                 m_valid;
    logic                 m_ready;
    logic [IDX_W-1:0]     m_partial_index;
    int                   fail_count;
    int                   pending_count;
    bit                   feeding_done;

    tensor_partial_index dut (.*);
    tpi_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("tensor_partial_index: mismatch");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_index(logic [IDX_W-1:0] full, logic [NODE_W-1:0] node);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_full_index <= full;
        s_node_select <= node;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [ROW_W-1:0] random_row(int len);
        logic [ROW_W-1:0] r;
        r = ROW_W'($urandom);
        r[27:24] = 4'(len);
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] random_radices(int mode);
        logic [CFG_W-1:0] t;
        t = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            if (mode == 0) begin
                t[i*8 +: 8] = 8'($urandom_range(0, 5));
            end else if (mode == 1) begin
                t[i*8 +: 8] = 8'($urandom_range(0, 17));
            end
        end
        return t;
    endfunction

    task automatic configure(int dims, logic [CFG_W-1:0] radix_bits, int mode);
        int len;
        write_reg(REG_DIM_COUNT, CFG_W'(dims));
        write_reg(REG_RADIX_TABLE, radix_bits);
        for (int i = 0; i < NODE_COUNT; i++) begin
            if (mode == 0) begin
                len = (dims > 8 || dims == 0) ? $urandom_range(0, 15) : dims;
            end else begin
                len = $urandom_range(0, 15);
            end
            write_reg(REG_ROW_ZERO + CFG_IDX_W'(i), CFG_W'(random_row(len)));
        end
    endtask

    initial begin
        logic [IDX_W-1:0] idx;
        int dims;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_full_index = '0;
        s_node_select = '0;
        feeding_done = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings first, then the extremes of the fields.
        send_index('0, 2'd0);
        send_index('1, 2'd3);
        drain_pipeline();
        configure(8, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_index('1, 2'd0);
        send_index('0, 2'd1);
        send_index(31'h5555_5555, 2'd2);
        send_index(31'h2AAA_AAAA, 2'd3);
        drain_pipeline();
        write_reg(REG_DIM_COUNT, 64'd0);
        write_reg(REG_RADIX_TABLE, 64'h0000_0000_0000_0000);
        write_reg(REG_ROW_ZERO, 64'h0FFF_FFFF);
        write_reg(REG_ROW_ONE, 64'h0000_0000);
        write_reg(REG_ROW_TWO, 64'h01FA_C688);
        write_reg(REG_ROW_THREE, 64'h0800_0000);
        for (int n = 0; n < 4; n++) begin
            send_index('1, NODE_W'(n));
        end
        drain_pipeline();
        write_reg(REG_DIM_COUNT, 64'd15);
        write_reg(REG_RADIX_TABLE, 64'h0300_FF02_0705_0003);
        write_reg(REG_ROW_ZERO, 64'h08FA_C688);
        write_reg(REG_ROW_ONE, 64'h0300_0007);
        write_reg(REG_ROW_TWO, 64'h0F00_0000 | 64'h0123_4567);
        write_reg(REG_ROW_THREE, 64'h0500_7FFF);
        for (int n = 0; n < 8; n++) begin
            send_index(IDX_W'($urandom), NODE_W'(n));
        end
        drain_pipeline();

        for (int phase = 0; phase < 14; phase++) begin
            dims = (phase % 5 == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            configure(dims, random_radices(phase % 3), phase % 2);
            for (int k = 0; k < 125; k++) begin
                idx = IDX_W'($urandom);
                if ($urandom_range(0, 2) == 0) begin
                    idx = idx >> $urandom_range(0, 30);
                end
                send_index(idx, NODE_W'($urandom_range(0, 3)));
            end
            drain_pipeline();
        end
        feeding_done = 1'b1;
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        @(posedge aclk);
        wait (feeding_done);
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tensor_partial_index: match");
        end else begin
            $display("tensor_partial_index: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/tpi_pkg.sv
src/tensor_partial_index.sv
src/tpi_checker.sv
sim/tpi_checker.sv
sim/tb_top.sv
